/* hw/rtl/dspwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspwm_pkg
// Shared types and fixed constants for the differential-steer PWM drive.
// ----------------------------------------------------------------------------
package dspwm_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Motor commands
  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_BASE_LEFT      = 3'd0;
  localparam logic [2:0] CFG_BASE_RIGHT     = 3'd1;
  localparam logic [2:0] CFG_STEER_GAIN     = 3'd2;
  localparam logic [2:0] CFG_SPEED_OVERRIDE = 3'd3;
  localparam logic [2:0] CFG_MID_THRESHOLD  = 3'd4;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int DUTY_W   = 7;
  localparam int GAIN_W   = 12;
  localparam int LEVEL_W  = 24;   // Q16.8 signed
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int FRAC_W   = 8;

  // Reset values
  localparam logic [DUTY_W-1:0]   BASE_RESET   = 7'd40;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 12'd59;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 10'd350;

  // Motor decision constants, Q.8 scaled
  localparam int REV_LEVEL  = 2560;    // 10.0
  localparam int REV_OFFSET = 296960;  // 11.6 * 25600
  localparam int PHASE_MUL  = 25600;   // 100 * 256

endpackage

/* hw/rtl/differential_steer_pwm_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_steer_pwm_drive
// Two-motor line-follower drive: incremental steering on sensor samples,
// PWM phase counter and per-motor command on ticks, level reload on restarts.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transfer content
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tuser: operation; tdata: sample_left/right/mid
//  m_axis   | out | tdata: left_mode, right_mode, phase (tick items only)
//  cfg      | in  | write-only register port, index + data, no wait
//
//  One item per cycle while s_axis_tready is high. Every item is handled in
//  the cycle it is accepted. The result side has an output register plus a
//  one-entry skid register that takes a tick result while the output stalls,
//  so s_axis_tready is a register bit: it drops only while skid holds a result.
//  rst (synchronous) restores the config defaults, both levels to 40.0,
//  the phase count and error history to zero, and empties the output side.
//
module differential_steer_pwm_drive #(
  parameter int PWM_PERIOD  = 100,
  parameter int SENSOR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [9:0] sample_left, [19:10] sample_right,
                                      // [29:20] sample_mid, [31:30] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] left_mode, [3:2] right_mode,
                                      // [10:4] phase, [15:11] zero
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import dspwm_pkg::*;

  // Phase counter holds 0..PWM_PERIOD
  localparam int PH_W  = $clog2(PWM_PERIOD + 1);
  localparam int CMP_W = (PH_W > DUTY_W) ? PH_W : DUTY_W;
  // Width for the reverse-duty compare: 16*level and p*25600 both fit
  localparam int MW    = 31;
  localparam int SB_USE = (SENSOR_BITS < SAMPLE_W) ? SENSOR_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = ~({SAMPLE_W{1'b1}} << SB_USE);
  localparam logic [PH_W-1:0] PERIOD = PH_W'(PWM_PERIOD);
  localparam int RES_W = 2 + 2 + DUTY_W;

  // Configuration registers
  logic [DUTY_W-1:0]   base_left, base_right, speed_override;
  logic [GAIN_W-1:0]   steer_gain;
  logic [SAMPLE_W-1:0] mid_threshold;

  // Drive state
  logic signed [ERR_W-1:0]   prev_error, prev_error_next;
  logic signed [LEVEL_W-1:0] left_level, left_level_next;
  logic signed [LEVEL_W-1:0] right_level, right_level_next;
  logic [PH_W-1:0]           phase_count, phase_count_next;
  logic                      mid_flag, mid_flag_next;

  // Output register and skid entry
  logic [RES_W-1:0] out_data, skid_data;
  logic             out_valid, skid_valid;

  logic       in_xfer;
  op_t        op;
  logic       res_new;
  logic [RES_W-1:0] res_data;

  // Sample datapath
  logic [SAMPLE_W-1:0]       sl, sr, sm;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     derr;
  logic signed [LEVEL_W-1:0] step;
  logic signed [LEVEL_W-1:0] half;
  logic signed [LEVEL_W:0]   left_sum, right_sum;

  // Tick datapath
  logic [PH_W-1:0] p;
  logic            ovr_on;
  mode_t           lmode, rmode;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign op            = op_t'(s_axis_tuser);

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      base_left      <= BASE_RESET;
      base_right     <= BASE_RESET;
      steer_gain     <= GAIN_RESET;
      speed_override <= '0;
      mid_threshold  <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_LEFT:      base_left      <= cfg_data[DUTY_W-1:0];
        CFG_BASE_RIGHT:     base_right     <= cfg_data[DUTY_W-1:0];
        CFG_STEER_GAIN:     steer_gain     <= cfg_data[GAIN_W-1:0];
        CFG_SPEED_OVERRIDE: speed_override <= cfg_data[DUTY_W-1:0];
        CFG_MID_THRESHOLD:  mid_threshold  <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- steering update ----
  // step = gain * (err - prev_error) is exact in 24 bits signed;
  // half = floor(step / 2) is an arithmetic shift.
  assign sl   = s_axis_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
  assign sr   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] & SAMPLE_MASK;
  assign sm   = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W] & SAMPLE_MASK;
  assign err  = $signed({1'b0, sl}) - $signed({1'b0, sr});
  assign derr = $signed({err[ERR_W-1], err}) - $signed({prev_error[ERR_W-1], prev_error});
  assign step = $signed({{(LEVEL_W-GAIN_W){1'b0}}, steer_gain})
              * $signed({{(LEVEL_W-ERR_W-1){derr[ERR_W]}}, derr});
  assign half = step >>> 1;
  assign left_sum  = $signed({left_level[LEVEL_W-1], left_level})
                   - $signed({half[LEVEL_W-1], half});
  assign right_sum = $signed({right_level[LEVEL_W-1], right_level})
                   + $signed({half[LEVEL_W-1], half});

  function automatic logic signed [LEVEL_W-1:0] sat_level(
    input logic signed [LEVEL_W:0] v
  );
    logic signed [LEVEL_W-1:0] r;
    if (v[LEVEL_W] != v[LEVEL_W-1]) begin
      r = v[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

  // ---- motor decision ----
  // Below 10.0: reverse while p*25600 < 296960 - 16*L.
  // At or above 10.0: forward while p*256 < L.
  function automatic mode_t motor_mode(
    input logic [PH_W-1:0]           ph,
    input logic signed [LEVEL_W-1:0] lv
  );
    logic signed [MW-1:0] ph_x, lv_x, lhs, rhs;
    mode_t m;
    ph_x = $signed(MW'(ph));
    lv_x = {{(MW-LEVEL_W){lv[LEVEL_W-1]}}, lv};
    m    = MODE_STOP;
    if (lv_x < MW'(REV_LEVEL)) begin
      lhs = ph_x * MW'(PHASE_MUL);
      rhs = $signed(MW'(REV_OFFSET)) - (lv_x <<< 4);
      if (lhs < rhs) m = MODE_REVERSE;
    end else begin
      if ((ph_x <<< FRAC_W) < lv_x) m = MODE_FORWARD;
    end
    return m;
  endfunction

  assign p      = (phase_count >= PERIOD) ? '0 : phase_count;
  assign ovr_on = (speed_override != '0) && mid_flag;

  always_comb begin
    if (ovr_on) begin
      lmode = (CMP_W'(p) < CMP_W'(speed_override)) ? MODE_FORWARD : MODE_STOP;
      rmode = lmode;
    end else begin
      lmode = motor_mode(p, left_level);
      rmode = motor_mode(p, right_level);
    end
  end

  assign res_data = {DUTY_W'(p), rmode, lmode};

  // ---- item dispatch ----
  always_comb begin
    prev_error_next  = prev_error;
    left_level_next  = left_level;
    right_level_next = right_level;
    phase_count_next = phase_count;
    mid_flag_next    = mid_flag;
    res_new          = 1'b0;
    if (in_xfer) begin
      case (op)
        OP_SAMPLE: begin
          prev_error_next  = err;
          left_level_next  = sat_level(left_sum);
          right_level_next = sat_level(right_sum);
          mid_flag_next    = sm > mid_threshold;
        end
        OP_TICK: begin
          phase_count_next = p + PH_W'(1);
          res_new          = 1'b1;
        end
        OP_RESTART: begin
          left_level_next  = $signed(LEVEL_W'({base_left, {FRAC_W{1'b0}}}));
          right_level_next = $signed(LEVEL_W'({base_right, {FRAC_W{1'b0}}}));
          prev_error_next  = '0;
        end
        default: ;  // unused code: no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error  <= '0;
      left_level  <= $signed(LEVEL_W'({BASE_RESET, {FRAC_W{1'b0}}}));
      right_level <= $signed(LEVEL_W'({BASE_RESET, {FRAC_W{1'b0}}}));
      phase_count <= '0;
      mid_flag    <= 1'b0;
    end else begin
      prev_error  <= prev_error_next;
      left_level  <= left_level_next;
      right_level <= right_level_next;
      phase_count <= phase_count_next;
      mid_flag    <= mid_flag_next;
    end
  end

  // ---- result output: output register + skid entry ----
  // Skid fills only when the output register holds and a new result arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= res_new;
      end
    end else if (res_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : res_data;
    end else if (res_new) begin
      skid_data <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16-RES_W){1'b0}}, out_data};

endmodule
